/* sv/line_segment_intersect_2d_unit_macros.svh */
// ----------------------------------------------------------------------------
// line segment intersection unit: assertion macros
// implication checks on clk; the overlapping one is disabled during rst
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_INTERSECT_2D_UNIT_MACROS_SVH
`define LINE_SEGMENT_INTERSECT_2D_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LSI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsi check failed");
`define LSI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lsi check failed");
`else
`define LSI_ASSERT_IMP(name, ante, cons)
`define LSI_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* sv/lsi_pkg.sv */
// ----------------------------------------------------------------------------
// lsi_pkg
// payload types, stage records and status codes of the intersection unit
// ----------------------------------------------------------------------------
package lsi_pkg;

  localparam int EpsWidth = 31;

  localparam logic [1:0] ST_PARALLEL = 2'd0;
  localparam logic [1:0] ST_INSIDE   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_dx;
    logic signed [15:0] a_dy;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_dx;
    logic signed [15:0] b_dy;
  } lsi_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] t_first;
    logic signed [31:0] t_second;
    logic signed [15:0] cross_x;
    logic signed [15:0] cross_y;
  } lsi_out_t;

  typedef struct packed {
    logic               par;
    logic               neg_t;
    logic               neg_u;
    logic [49:0]        dend_t;
    logic [49:0]        dend_u;
    logic [31:0]        dvsr;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_dx;
    logic signed [15:0] a_dy;
  } lsi_req_t;

  typedef struct packed {
    logic               par;
    logic               neg_t;
    logic               neg_u;
    logic               ovf_t;
    logic               ovf_u;
    logic [31:0]        dvsr;
    logic [31:0]        rem_t;
    logic [31:0]        rem_u;
    logic [31:0]        q_t;
    logic [31:0]        q_u;
    logic [31:0]        lo_t;
    logic [31:0]        lo_u;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_dx;
    logic signed [15:0] a_dy;
  } lsi_div_st_t;

endpackage

/* sv/lsi_front.sv */
// ----------------------------------------------------------------------------
// lsi_front
// three stages: products, determinant and numerators, magnitudes and eps test
// ----------------------------------------------------------------------------
module lsi_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  lsi_pkg::lsi_in_t                  in_data,
  input  logic [lsi_pkg::EpsWidth-1:0]      eps,
  output logic                              out_valid,
  output lsi_pkg::lsi_req_t                 req
);
  import lsi_pkg::*;

  logic               v1, v2;
  lsi_in_t            s1;
  logic signed [31:0] p_ab, p_ba;
  logic signed [16:0] dx, dy;

  lsi_in_t            s2;
  logic signed [32:0] det;
  logic signed [32:0] m1, m2, m3, m4;

  logic signed [33:0] nt, nu;
  logic [32:0]        mag;
  logic [33:0]        ntm, num;
  lsi_req_t           req_next;

  always_comb begin
    nt  = 34'(m1) - 34'(m2);
    nu  = 34'(m3) - 34'(m4);
    mag = det[32] ? 33'(-det) : 33'(det);
    ntm = nt[33] ? 34'(-nt) : 34'(nt);
    num = nu[33] ? 34'(-nu) : 34'(nu);
    req_next.par    = mag[31:0] <= {1'b0, eps} && !mag[32];
    req_next.neg_t  = nt[33] ^ det[32];
    req_next.neg_u  = nu[33] ^ det[32];
    req_next.dend_t = {ntm[33:0], 16'b0};
    req_next.dend_u = {num[33:0], 16'b0};
    req_next.dvsr   = mag[31:0];
    req_next.a_x    = s2.a_x;
    req_next.a_y    = s2.a_y;
    req_next.a_dx   = s2.a_dx;
    req_next.a_dy   = s2.a_dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      // products of the direction vectors and start differences
      s1   <= in_data;
      p_ab <= in_data.a_dx * in_data.b_dy;
      p_ba <= in_data.a_dy * in_data.b_dx;
      dx   <= 17'(in_data.a_x) - 17'(in_data.b_x);
      dy   <= 17'(in_data.a_y) - 17'(in_data.b_y);
      s2   <= s1;
      det  <= 33'(p_ab) - 33'(p_ba);
      m1   <= 33'(s1.b_dx) * 33'(dy);
      m2   <= 33'(s1.b_dy) * 33'(dx);
      m3   <= 33'(s1.a_dx) * 33'(dy);
      m4   <= 33'(s1.a_dy) * 33'(dx);
      req  <= req_next;
    end
  end

endmodule

/* sv/lsi_div.sv */
// ----------------------------------------------------------------------------
// lsi_div
// pipelined restoring divider, a setup stage then one quotient bit per stage for both parameters
// ----------------------------------------------------------------------------
module lsi_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  lsi_pkg::lsi_req_t    req,
  output logic                 out_valid,
  output lsi_pkg::lsi_div_st_t res
);
  import lsi_pkg::*;

  localparam int Steps = 32;

  lsi_div_st_t      st [Steps+1];
  logic [Steps:0]   vld;
  lsi_div_st_t      st0_next;

  function automatic lsi_div_st_t div_step(lsi_div_st_t s);
    lsi_div_st_t r;
    logic [32:0] rt, ru;
    r  = s;
    rt = {s.rem_t, s.lo_t[31]};
    ru = {s.rem_u, s.lo_u[31]};
    r.lo_t = {s.lo_t[30:0], 1'b0};
    r.lo_u = {s.lo_u[30:0], 1'b0};
    if (rt >= {1'b0, s.dvsr}) begin
      r.rem_t = 32'(rt - {1'b0, s.dvsr});
      r.q_t   = {s.q_t[30:0], 1'b1};
    end else begin
      r.rem_t = rt[31:0];
      r.q_t   = {s.q_t[30:0], 1'b0};
    end
    if (ru >= {1'b0, s.dvsr}) begin
      r.rem_u = 32'(ru - {1'b0, s.dvsr});
      r.q_u   = {s.q_u[30:0], 1'b1};
    end else begin
      r.rem_u = ru[31:0];
      r.q_u   = {s.q_u[30:0], 1'b0};
    end
    return r;
  endfunction

  // quotient at or above 2^32 is flagged up front
  always_comb begin
    st0_next.par   = req.par;
    st0_next.neg_t = req.neg_t;
    st0_next.neg_u = req.neg_u;
    st0_next.ovf_t = {14'b0, req.dend_t[49:32]} >= req.dvsr;
    st0_next.ovf_u = {14'b0, req.dend_u[49:32]} >= req.dvsr;
    st0_next.dvsr  = req.dvsr;
    st0_next.rem_t = {14'b0, req.dend_t[49:32]};
    st0_next.rem_u = {14'b0, req.dend_u[49:32]};
    st0_next.q_t   = '0;
    st0_next.q_u   = '0;
    st0_next.lo_t  = req.dend_t[31:0];
    st0_next.lo_u  = req.dend_u[31:0];
    st0_next.a_x   = req.a_x;
    st0_next.a_y   = req.a_y;
    st0_next.a_dx  = req.a_dx;
    st0_next.a_dy  = req.a_dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Steps-1:0], in_valid};
    end
    if (adv) begin
      st[0] <= st0_next;
      for (int k = 1; k <= Steps; k++) begin
        st[k] <= div_step(st[k-1]);
      end
    end
  end

  assign out_valid = vld[Steps];
  assign res       = st[Steps];

endmodule

/* sv/lsi_back.sv */
// ----------------------------------------------------------------------------
// lsi_back
// sign and saturation, segment test, point on first line, output register
// ----------------------------------------------------------------------------
module lsi_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  lsi_pkg::lsi_div_st_t res,
  output logic                 out_valid,
  output lsi_pkg::lsi_out_t    out_data
);
  import lsi_pkg::*;

  localparam logic signed [31:0] One = 32'sd65536;

  logic               v1, v2;
  logic               par1, par2;
  logic signed [31:0] t1, u1, t2, u2;
  logic [1:0]         st1, st2;
  logic signed [15:0] ax1, ay1, adx1, ady1, ax2, ay2;
  logic signed [47:0] px2, py2;

  logic signed [31:0] t_next, u_next;
  logic signed [48:0] sum_x, sum_y;
  lsi_out_t           out_next;

  function automatic logic signed [31:0] sat_q(logic neg, logic ovf, logic [31:0] q);
    logic signed [31:0] r;
    if (!neg) begin
      r = (ovf || q[31]) ? 32'sh7fff_ffff : signed'(q);
    end else begin
      r = (ovf || (q[31] && q[30:0] != '0)) ? 32'sh8000_0000 : signed'(-q);
    end
    return r;
  endfunction

  // floor of the sum without 16 fraction bits, clamped to 16 bits
  function automatic logic signed [15:0] sat_pt(logic signed [48:0] s);
    logic [32:0] fl;
    fl = s[48:16];
    if (fl[32:15] == {18{fl[15]}}) return signed'(fl[15:0]);
    return fl[32] ? 16'sh8000 : 16'sh7fff;
  endfunction

  always_comb begin
    t_next = sat_q(res.neg_t, res.ovf_t, res.q_t);
    u_next = sat_q(res.neg_u, res.ovf_u, res.q_u);
    sum_x  = {{17{ax2[15]}}, ax2, 16'b0} + 49'(px2);
    sum_y  = {{17{ay2[15]}}, ay2, 16'b0} + 49'(py2);
    if (par2) begin
      out_next = '0;
      out_next.status = ST_PARALLEL;
    end else begin
      out_next.status   = st2;
      out_next.t_first  = t2;
      out_next.t_second = u2;
      out_next.cross_x  = sat_pt(sum_x);
      out_next.cross_y  = sat_pt(sum_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      par1 <= res.par;
      t1   <= t_next;
      u1   <= u_next;
      st1  <= (t_next >= 0 && t_next <= One && u_next >= 0 && u_next <= One) ?
              ST_INSIDE : ST_OUTSIDE;
      ax1  <= res.a_x;
      ay1  <= res.a_y;
      adx1 <= res.a_dx;
      ady1 <= res.a_dy;
      par2 <= par1;
      t2   <= t1;
      u2   <= u1;
      st2  <= st1;
      ax2  <= ax1;
      ay2  <= ay1;
      px2  <= 48'(t1) * 48'(adx1);
      py2  <= 48'(t1) * 48'(ady1);
      out_data <= out_next;
    end
  end

endmodule

/* sv/line_segment_intersect_2d_unit.sv */
// ----------------------------------------------------------------------------
// line_segment_intersect_2d_unit
// intersection of two parametric 2d lines, one query per clock while the output is not stalled
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_ready   lsi_in_t   in_data
//   out      output     out_valid/out_ready lsi_out_t  out_data
//   cfg      input      cfg_we              cfg_wdata  (parallel_eps)
//
// from transfer in to result valid a query passes 3 front stages,
// 33 divider stages (a setup stage, then one quotient bit per stage) and 3 back stages.
// one item per cycle sustained while out_ready is high.
// a stall at the output freezes every stage; nothing is dropped or repeated.
// rst (synchronous) clears all valid bits and parallel_eps.
// ----------------------------------------------------------------------------
`include "line_segment_intersect_2d_unit_macros.svh"

module line_segment_intersect_2d_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lsi_pkg::lsi_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lsi_pkg::lsi_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [lsi_pkg::EpsWidth-1:0]  cfg_wdata
);
  import lsi_pkg::*;

  logic [EpsWidth-1:0] parallel_eps;
  logic                adv;
  logic                fv, dv;
  lsi_req_t            req;
  lsi_div_st_t         res;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_eps <= '0;
    end else if (cfg_we) begin
      parallel_eps <= cfg_wdata;
    end
  end

  lsi_front u_front (
    .clk, .rst, .adv,
    .in_valid (in_valid && in_ready),
    .in_data,
    .eps      (parallel_eps),
    .out_valid(fv),
    .req
  );

  lsi_div u_div (
    .clk, .rst, .adv,
    .in_valid (fv),
    .req,
    .out_valid(dv),
    .res
  );

  lsi_back u_back (
    .clk, .rst, .adv,
    .in_valid (dv),
    .res,
    .out_valid,
    .out_data
  );

  `LSI_ASSERT_IMP(a_par_zero, out_valid && out_data.status == ST_PARALLEL, out_data.t_first == 0 && out_data.t_second == 0 && out_data.cross_x == 0 && out_data.cross_y == 0)
  `LSI_ASSERT_IMP(a_inside, out_valid && out_data.status == ST_INSIDE, out_data.t_first >= 0 && out_data.t_first <= 32'sd65536 && out_data.t_second >= 0 && out_data.t_second <= 32'sd65536)
  `LSI_ASSERT_IMP(a_outside, out_valid && out_data.status == ST_OUTSIDE, out_data.t_first < 0 || out_data.t_first > 32'sd65536 || out_data.t_second < 0 || out_data.t_second > 32'sd65536)
  `LSI_ASSERT_NXT(a_reset, rst, !out_valid && parallel_eps == '0)

endmodule
